// ===== rtl/core/pdbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbf_pkg
// Shared types and constants for the packet dedup Bloom filter.
// ----------------------------------------------------------------------------
package pdbf_pkg;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam int VEC_W      = 64;
  localparam int IDX_W      = 6;
  localparam int ELAPSED_W  = 25;
  localparam int INTERVAL_W = 24;
  localparam int KEY_LOW_W  = 9;   // key bits that reach the bit indices

  localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX    = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd300000;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_INTERVAL   = 1'b0;
  localparam logic REG_AUTO_CLEAR = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic                  auto_clear;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;
  } cmd_t;

endpackage

// ===== rtl/core/packet_dedup_bloom_filter_top.sv =====
// ----------------------------------------------------------------------------
// packet_dedup_bloom_filter_top
// Duplicate-packet filter over a 64-bit two-hash Bloom vector.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the opcode (check, add, clear, tick), s_tdata
// the packet id, destination and source address. Each transfer in gives
// exactly one transfer out on m_tdata: seen and cleared.
// The header hash runs in a three-stage pipeline, feeds a four-entry command
// queue, and the back end updates the vector and the millisecond counter as
// it takes each item into the output register. Throughput is one item per
// cycle while m_tready is high.
// When m_tready is low the result holds in the output register; the queue
// fills, the pipeline stalls once its last stage is valid, and s_tready drops.
// Reset (rst, synchronous) empties the pipeline and queue, zeroes the vector
// and the counter, and loads the registers with their defaults: interval
// 300000 ms at address 0, auto clear enabled at address 4. Configure only
// while no items are in flight.
// ----------------------------------------------------------------------------
module packet_dedup_bloom_filter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,  // packet_id, dest_address, source_address
  input  logic [1:0]                    s_tuser,  // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // seen, cleared, zero pad
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdbf_pkg::PADDR_W-1:0]  paddr,
  input  logic [pdbf_pkg::PDATA_W-1:0]  pwdata,
  output logic [pdbf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pdbf_pkg::*;

  cfg_t cfg;
  logic cfg_write;
  logic reg_sel;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;
  logic seen;
  logic cleared;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval   <= INTERVAL_RESET;
      cfg.auto_clear <= 1'b1;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_INTERVAL:   cfg.interval   <= pwdata[INTERVAL_W-1:0];
        REG_AUTO_CLEAR: cfg.auto_clear <= pwdata[0];
        default:        cfg.auto_clear <= cfg.auto_clear;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INTERVAL:   prdata = PDATA_W'(cfg.interval);
      REG_AUTO_CLEAR: prdata = PDATA_W'(cfg.auto_clear);
      default:        prdata = '0;
    endcase
  end

  pdbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op_t'(s_tuser)),
    .in_pid    (s_tdata[7:0]),
    .in_dst    (s_tdata[23:8]),
    .in_src    (s_tdata[39:24]),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  pdbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  pdbf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_seen    (seen),
    .out_cleared (cleared)
  );

  assign m_tdata = {6'b000000, cleared, seen};

endmodule

// ===== rtl/core/pdbf_front.sv =====
// ----------------------------------------------------------------------------
// pdbf_front
// Accepts items and hashes the header into two filter bit indices over a
// three-stage pipeline; only the low key bits that reach the indices are kept.
// ----------------------------------------------------------------------------
module pdbf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdbf_pkg::op_t        in_op,
  input  logic [7:0]           in_pid,
  input  logic [15:0]          in_dst,
  input  logic [15:0]          in_src,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output pdbf_pkg::cmd_t       cmd
);
  import pdbf_pkg::*;

  // stage 1: inner pair sum, only mod 2^12 matters
  logic        v1;
  op_t         op1;
  logic [7:0]  pid1;
  logic [11:0] s1;
  logic [10:0] src1;
  // stage 2: inner fold H(dst,src), low 11 bits
  logic        v2;
  op_t         op2;
  logic [7:0]  pid2;
  logic [10:0] h1;
  // stage 3: key low bits
  logic        v3;
  op_t         op3;
  logic [KEY_LOW_W-1:0] key3;

  logic        adv;
  logic [11:0] s1_in;
  logic [11:0] prod1;
  logic [10:0] h1_next;
  logic [10:0] s2;
  logic [10:0] prod2;
  logic [9:0]  sum2;
  logic [KEY_LOW_W-1:0] key_next;
  logic [IDX_W-1:0] k6;
  logic [IDX_W-1:0] mul31;
  logic [IDX_W-1:0] mul17;

  assign adv      = !v3 || cmd_ready;
  assign in_ready = adv;

  assign s1_in   = in_dst[11:0] + in_src[11:0];
  assign prod1   = s1 * (s1 + 12'd1);
  assign h1_next = prod1[11:1] + src1;

  assign s2       = h1 + {3'b000, pid2};
  assign prod2    = s2 * (s2 + 11'd1);
  assign sum2     = prod2[10:1] + h1[9:0];
  assign key_next = sum2[9:1];

  assign k6    = key3[IDX_W-1:0];
  assign mul31 = (k6 << 5) - k6;
  assign mul17 = (k6 << 4) + k6;

  assign cmd_valid = v3;
  assign cmd.op    = op3;
  assign cmd.idx1  = mul31;
  assign cmd.idx2  = key3[8:3] ^ mul17;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= in_op;
      pid1 <= in_pid;
      s1   <= s1_in;
      src1 <= in_src[10:0];
      op2  <= op1;
      pid2 <= pid1;
      h1   <= h1_next;
      op3  <= op2;
      key3 <= key_next;
    end
  end

endmodule

// ===== rtl/core/pdbf_queue.sv =====
// ----------------------------------------------------------------------------
// pdbf_queue
// Short command queue between the hash front end and the filter back end.
// ----------------------------------------------------------------------------
module pdbf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pdbf_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pdbf_pkg::cmd_t pop_cmd
);
  import pdbf_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/core/pdbf_back.sv =====
// ----------------------------------------------------------------------------
// pdbf_back
// Holds the 64-bit filter vector and the millisecond counter, executes one
// command per cycle while the output register is empty or being read, and keeps the result in it.
// ----------------------------------------------------------------------------
module pdbf_back (
  input  logic           clk,
  input  logic           rst,
  input  pdbf_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pdbf_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_seen,
  output logic           out_cleared
);
  import pdbf_pkg::*;

  logic [VEC_W-1:0]     vector;
  logic [VEC_W-1:0]     vector_next;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [VEC_W-1:0]     mask;
  logic                 seen_next;
  logic                 cleared_next;
  logic                 take;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  assign mask        = (VEC_W'(1) << cmd.idx1) | (VEC_W'(1) << cmd.idx2);
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + ELAPSED_W'(1);

  always_comb begin
    vector_next  = vector;
    elapsed_next = elapsed;
    seen_next    = 1'b0;
    cleared_next = 1'b0;
    case (cmd.op)
      OP_CHECK: begin
        seen_next = (vector & mask) == mask;
      end
      OP_ADD: begin
        seen_next   = (vector & mask) == mask;
        vector_next = vector | mask;
      end
      OP_CLEAR: begin
        vector_next  = '0;
        cleared_next = 1'b1;
      end
      OP_TICK: begin
        elapsed_next = elapsed_inc;
        if (cfg.auto_clear && (elapsed_inc > {1'b0, cfg.interval})) begin
          vector_next  = '0;
          elapsed_next = '0;
          cleared_next = 1'b1;
        end
      end
      default: begin
        vector_next = vector;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector    <= '0;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        vector    <= vector_next;
        elapsed   <= elapsed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_seen    <= seen_next;
      out_cleared <= cleared_next;
    end
  end

endmodule

// ===== verif/packet_dedup_bloom_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// packet_dedup_bloom_filter_top_tb
// Self-checking bench for the packet dedup Bloom filter.
// A local model keeps its own copy of the 64-bit vector, the millisecond
// counter and the two registers, and predicts seen/cleared for every input
// transfer. Directed items cover the header extremes, every opcode, equal bit
// indices and the timed clear. Random phases follow under several register
// settings, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module packet_dedup_bloom_filter_top_tb;
  import pdbf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT    = 12;
  localparam int DRAIN_WAIT  = 8;
  localparam int STALL_LEN   = 120;
  localparam logic [31:0] HASH_MUL_A = 32'd31;
  localparam logic [31:0] HASH_MUL_B = 32'd17;

  typedef struct packed {
    logic seen;
    logic cleared;
  } verdict_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         s_tdata  = '0;  // packet_id, dest_address, source_address
  logic [1:0]          s_tuser  = '0;  // opcode
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;        // seen, cleared, zero pad
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [PDATA_W-1:0]  pwdata   = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // model state
  logic [VEC_W-1:0]      shadow_vec;
  logic [ELAPSED_W-1:0]  shadow_ms;
  logic [INTERVAL_W-1:0] cfg_interval;
  logic                  cfg_auto;

  verdict_t    verdict_q[$];
  logic [39:0] hdr_pool[16];
  int          mismatches = 0;
  int          cycle_cnt  = 0;
  bit          idle_en    = 1'b1;
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;

  packet_dedup_bloom_filter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  // Cantor pairing, triangle formed in 64 bits then wrapped to 32
  function automatic logic [31:0] cantor_pair(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    logic [63:0] tri_v;
    s     = a + b;
    tri_v = ({32'd0, s} * ({32'd0, s} + 64'd1)) >> 1;
    return tri_v[31:0] + b;
  endfunction

  function automatic void hash_indices(input logic [7:0] pid, input logic [15:0] dst,
                                       input logic [15:0] src,
                                       output logic [IDX_W-1:0] i1,
                                       output logic [IDX_W-1:0] i2);
    logic [31:0] key;
    logic [31:0] mix_a;
    logic [31:0] mix_b;
    key   = cantor_pair({24'd0, pid}, cantor_pair({16'd0, dst}, {16'd0, src})) >> 1;
    mix_a = key * HASH_MUL_A;
    mix_b = (key >> 3) ^ (key * HASH_MUL_B);
    i1    = mix_a[IDX_W-1:0];
    i2    = mix_b[IDX_W-1:0];
  endfunction

  function automatic void filter_predict(input op_t op, input logic [7:0] pid,
                                         input logic [15:0] dst, input logic [15:0] src,
                                         output verdict_t v);
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    logic [VEC_W-1:0] mask;
    v = '0;
    case (op)
      OP_CHECK, OP_ADD: begin
        hash_indices(pid, dst, src, i1, i2);
        mask   = (64'd1 << i1) | (64'd1 << i2);
        v.seen = ((shadow_vec & mask) == mask);
        if (op == OP_ADD) shadow_vec |= mask;
      end
      OP_CLEAR: begin
        shadow_vec = '0;
        v.cleared  = 1'b1;
      end
      default: begin
        if (shadow_ms != ELAPSED_MAX) shadow_ms++;
        if (cfg_auto && shadow_ms > {1'b0, cfg_interval}) begin
          shadow_vec = '0;
          shadow_ms  = '0;
          v.cleared  = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s: expected %0h, got %0h (cycle %0d)", what, exp_v, act_v,
               cycle_cnt);
  endfunction

  function automatic logic [39:0] rand_header();
    logic [15:0] src;
    logic [15:0] dst;
    logic [7:0]  pid;
    src = 16'($urandom_range(16'hFFFF));
    dst = 16'($urandom_range(16'hFFFF));
    pid = 8'($urandom_range(8'hFF));
    return {src, dst, pid};
  endfunction

  // ------------------------------------------------------- result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, {30'd0, m_tdata[1:0]});
      end else begin
        verdict_t exp_v;
        exp_v = verdict_q.pop_front();
        if (m_tdata[0] !== exp_v.seen)
          note_mismatch("seen", {31'd0, exp_v.seen}, {31'd0, m_tdata[0]});
        if (m_tdata[1] !== exp_v.cleared)
          note_mismatch("cleared", {31'd0, exp_v.cleared}, {31'd0, m_tdata[1]});
      end
    end
  end

  // output side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = STALL_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_item(input op_t op, input logic [7:0] pid, input logic [15:0] dst,
                           input logic [15:0] src);
    verdict_t v;
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {src, dst, pid};
    do @(posedge clk); while (!s_tready);
    filter_predict(op, pid, dst, src, v);
    verdict_q.push_back(v);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] want;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_INTERVAL) cfg_interval = value[INTERVAL_W-1:0];
    else                     cfg_auto     = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_INTERVAL) begin
      want = {8'd0, cfg_interval};
      rd   = rd & 32'h00FF_FFFF;
    end else begin
      want = {31'd0, cfg_auto};
      rd   = rd & 32'd1;
    end
    if (rd !== want) note_mismatch("register readback", want, rd);
  endtask

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_CHECK;
    if (r < 75) return OP_ADD;
    if (r < 80) return OP_CLEAR;
    return OP_TICK;
  endfunction

  // about half the headers are reused from a pool so that adds and checks actually hit
  task automatic run_random(input int count);
    logic [39:0] hdr;
    int slot;
    for (int i = 0; i < count; i++) begin
      slot = $urandom_range(15);
      if ($urandom_range(1)) begin
        hdr = hdr_pool[slot];
      end else begin
        hdr = rand_header();
        hdr_pool[slot] = hdr;
      end
      send_item(rand_op(), hdr[7:0], hdr[23:8], hdr[39:24]);
    end
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    logic [15:0] twin_src;
    twin_src = 16'd0;
    // header whose two indices coincide
    for (int s = 0; s < 65536; s++) begin
      hash_indices(8'd0, 16'd1, s[15:0], i1, i2);
      if (i1 == i2) begin
        twin_src = s[15:0];
        break;
      end
    end
    send_item(OP_CHECK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_ADD,   8'h00, 16'h0000, 16'h0000);
    send_item(OP_CHECK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_ADD,   8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_CHECK, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_CHECK, 8'hFF, 16'h0000, 16'hFFFF);
    send_item(OP_ADD,   8'h00, 16'hFFFF, 16'h0000);
    send_item(OP_ADD,   8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_CHECK, 8'h00, 16'h0001, twin_src);
    send_item(OP_ADD,   8'h00, 16'h0001, twin_src);
    send_item(OP_CHECK, 8'h00, 16'h0001, twin_src);
    send_item(OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_CHECK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_TICK,  8'hA5, 16'h5A5A, 16'hC3C3);
    send_item(OP_TICK,  8'h00, 16'h0000, 16'h0000);
  endtask

  task automatic test_timed_clear();
    write_reg(REG_INTERVAL, 32'd0);
    send_item(OP_TICK,  8'h00, 16'h0000, 16'h0000);
    send_item(OP_ADD,   8'h12, 16'h3456, 16'h789A);
    send_item(OP_TICK,  8'h00, 16'h0000, 16'h0000);
    send_item(OP_CHECK, 8'h12, 16'h3456, 16'h789A);
    write_reg(REG_INTERVAL, 32'd3);
    send_item(OP_ADD, 8'h12, 16'h3456, 16'h789A);
    repeat (4) send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_CHECK, 8'h12, 16'h3456, 16'h789A);
    // counting goes on while disabled; re-enable clears on the next tick
    write_reg(REG_AUTO_CLEAR, 32'd0);
    write_reg(REG_INTERVAL, 32'd2);
    send_item(OP_ADD, 8'h34, 16'h0102, 16'h0304);
    repeat (5) send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_CHECK, 8'h34, 16'h0102, 16'h0304);
    write_reg(REG_AUTO_CLEAR, 32'd1);
    send_item(OP_TICK,  8'h00, 16'h0000, 16'h0000);
    send_item(OP_CHECK, 8'h34, 16'h0102, 16'h0304);
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    repeat (3) send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
  endtask

  // output held off while the input keeps offering, so s_tready must drop
  task automatic test_backpressure();
    write_reg(REG_INTERVAL, 32'd7);
    hold_req = 1'b1;
    run_random(40);
  endtask

  task automatic run_phase(input int count, input logic [INTERVAL_W-1:0] interval,
                           input logic auto_clear, input bit idles);
    write_reg(REG_INTERVAL, {8'd0, interval});
    write_reg(REG_AUTO_CLEAR, {31'd0, auto_clear});
    idle_en = idles;
    run_random(count);
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    run_phase(250, INTERVAL_RESET, 1'b1, 1'b1);
    run_phase(150, 24'd0, 1'b1, 1'b1);
    run_phase(320, 24'($urandom_range(5, 60)), 1'b1, 1'b1);
    run_phase(150, 24'hFFFFFF, 1'b1, 1'b1);
    run_phase(200, 24'd12, 1'b0, 1'b1);
    run_phase(300, 24'($urandom_range(1, 30)), 1'b1, 1'b0);
  endtask

  initial begin
    shadow_vec   = '0;
    shadow_ms    = '0;
    cfg_interval = INTERVAL_RESET;
    cfg_auto     = 1'b1;
    for (int i = 0; i < 16; i++)
      hdr_pool[i] = rand_header();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_timed_clear();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== packet_dedup_bloom_filter_top.f =====
rtl/core/pdbf_pkg.sv
rtl/core/pdbf_front.sv
rtl/core/pdbf_queue.sv
rtl/core/pdbf_back.sv
rtl/core/packet_dedup_bloom_filter_top.sv
verif/packet_dedup_bloom_filter_top_tb.sv
